// ----- rtl/assert_macros.svh -----
// assertion macros for the rasterizer top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under active-low reset
`define TBR_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("assertion failed");

// next-cycle implication under active-low reset
`define TBR_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

// ----- rtl/tbr_pkg.sv -----
// constants shared by the triangle rasterizer modules
// no dependencies
`default_nettype none

package tbr_pkg;

    localparam int COLOR_BITS = 24;

    localparam logic OP_START = 1'b0;
    localparam logic OP_SCAN  = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/triangle_bbox_raster.sv -----
// Triangle rasterizer over the bounding box. A start item (operation 0) loads three vertices and
// a fill color and gives no result; each scan item (operation 1) gives one pixel of the box,
// columns outer and rows inner, with the max column and max row excluded, plus a covered flag,
// the color when covered and a last flag. A scan with no box pending gives pixel (0,0), not
// covered, last set. One item is taken per cycle while the queue has room; a scan result passes
// the queue, the edge product stage and the edge sum stage, then the coverage compare into the
// output register. A queue of QUEUE_DEPTH entries sits between the front and the product pipe,
// so the input stalls only once the output has been held long enough to fill it.
// depends on tbr_pkg, tbr_front, tbr_fifo, tbr_back and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module triangle_bbox_raster #(
    parameter int COORD_BITS  = 13,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          operation,
    input  wire logic signed [COORD_BITS-1:0]  vertex_a_x,
    input  wire logic signed [COORD_BITS-1:0]  vertex_a_y,
    input  wire logic signed [COORD_BITS-1:0]  vertex_b_x,
    input  wire logic signed [COORD_BITS-1:0]  vertex_b_y,
    input  wire logic signed [COORD_BITS-1:0]  vertex_c_x,
    input  wire logic signed [COORD_BITS-1:0]  vertex_c_y,
    input  wire logic [tbr_pkg::COLOR_BITS-1:0] fill_color,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [COORD_BITS-1:0]       pixel_x,
    output logic signed [COORD_BITS-1:0]       pixel_y,
    output logic                               covered,
    output logic [tbr_pkg::COLOR_BITS-1:0]     pixel_color,
    output logic                               last
);

    import tbr_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int QW = 2 * COORD_BITS + 6 * DW + COLOR_BITS + 2;

    logic                         f_valid, f_ready;
    logic signed [COORD_BITS-1:0] f_px, f_py;
    logic signed [DW-1:0]         f_dax, f_day, f_dbx, f_dby, f_dcx, f_dcy;
    logic [COLOR_BITS-1:0]        f_color;
    logic                         f_act, f_last;

    logic                         q_valid, q_ready;
    logic [QW-1:0]                f_data, q_data;
    logic signed [COORD_BITS-1:0] q_px, q_py;
    logic signed [DW-1:0]         q_dax, q_day, q_dbx, q_dby, q_dcx, q_dcy;
    logic [COLOR_BITS-1:0]        q_color;
    logic                         q_act, q_last;

    tbr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .vertex_a_x (vertex_a_x),
        .vertex_a_y (vertex_a_y),
        .vertex_b_x (vertex_b_x),
        .vertex_b_y (vertex_b_y),
        .vertex_c_x (vertex_c_x),
        .vertex_c_y (vertex_c_y),
        .fill_color (fill_color),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .px         (f_px),
        .py         (f_py),
        .dax        (f_dax),
        .day        (f_day),
        .dbx        (f_dbx),
        .dby        (f_dby),
        .dcx        (f_dcx),
        .dcy        (f_dcy),
        .color      (f_color),
        .act        (f_act),
        .last       (f_last)
    );

    assign f_data = {f_px, f_py, f_dax, f_day, f_dbx, f_dby, f_dcx, f_dcy, f_color, f_act, f_last};

    tbr_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    assign {q_px, q_py, q_dax, q_day, q_dbx, q_dby, q_dcx, q_dcy, q_color, q_act, q_last} = q_data;

    tbr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .px          (q_px),
        .py          (q_py),
        .dax         (q_dax),
        .day         (q_day),
        .dbx         (q_dbx),
        .dby         (q_dby),
        .dcx         (q_dcx),
        .dcy         (q_dcy),
        .color       (q_color),
        .act         (q_act),
        .last_in     (q_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .covered     (covered),
        .pixel_color (pixel_color),
        .last        (last)
    );

    // an uncovered pixel never carries a color
    `TBR_ASSERT_IMPLY(a_uncovered_no_color, clk, rst_n, out_valid && !covered, pixel_color == '0)
    // input stalls only when the queue is full, so it must hold something
    `TBR_ASSERT_IMPLY(a_stall_means_queued, clk, rst_n, !in_ready, q_valid)
    // a result that is not taken stays put
    `TBR_ASSERT_NEXT(a_out_held, clk, rst_n, out_valid && !out_ready,
                     out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(covered) && $stable(pixel_color) && $stable(last))

endmodule

`default_nettype wire

// ----- rtl/tbr_fifo.sv -----
// small register queue between the rasterizer front and back
// depends on nothing but its parameters
`default_nettype none

module tbr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tbr_front.sv -----
// rasterizer front: takes items, holds the triangle setup and walks the box
// depends on tbr_pkg
`default_nettype none

module tbr_front #(
    parameter int COORD_BITS = 13
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          operation,
    input  wire logic signed [COORD_BITS-1:0]  vertex_a_x,
    input  wire logic signed [COORD_BITS-1:0]  vertex_a_y,
    input  wire logic signed [COORD_BITS-1:0]  vertex_b_x,
    input  wire logic signed [COORD_BITS-1:0]  vertex_b_y,
    input  wire logic signed [COORD_BITS-1:0]  vertex_c_x,
    input  wire logic signed [COORD_BITS-1:0]  vertex_c_y,
    input  wire logic [tbr_pkg::COLOR_BITS-1:0] fill_color,
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output logic signed [COORD_BITS-1:0]       px,
    output logic signed [COORD_BITS-1:0]       py,
    output logic signed [COORD_BITS:0]         dax,
    output logic signed [COORD_BITS:0]         day,
    output logic signed [COORD_BITS:0]         dbx,
    output logic signed [COORD_BITS:0]         dby,
    output logic signed [COORD_BITS:0]         dcx,
    output logic signed [COORD_BITS:0]         dcy,
    output logic [tbr_pkg::COLOR_BITS-1:0]     color,
    output logic                               act,
    output logic                               last
);

    import tbr_pkg::*;

    localparam int DW = COORD_BITS + 1;

    logic signed [COORD_BITS-1:0] ax_reg, ay_reg;
    logic signed [DW-1:0]         dbx_reg, dby_reg, dcx_reg, dcy_reg;
    logic [COLOR_BITS-1:0]        color_reg;
    logic signed [COORD_BITS-1:0] minx_reg, miny_reg, maxx_reg, maxy_reg;
    logic signed [COORD_BITS-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic                         active_reg, active_next;

    logic signed [COORD_BITS-1:0] mnx, mny, mxx, mxy;
    logic signed [DW-1:0]         sx_inc, sy_inc;
    logic                         row_end, last_hit;
    logic                         accept, is_start;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;
    assign is_start = (operation == OP_START);

    // bounding box of the incoming vertices
    always_comb
    begin
        mnx = vertex_a_x;
        mxx = vertex_a_x;
        mny = vertex_a_y;
        mxy = vertex_a_y;
        if (vertex_b_x < mnx) mnx = vertex_b_x;
        if (vertex_c_x < mnx) mnx = vertex_c_x;
        if (vertex_b_x > mxx) mxx = vertex_b_x;
        if (vertex_c_x > mxx) mxx = vertex_c_x;
        if (vertex_b_y < mny) mny = vertex_b_y;
        if (vertex_c_y < mny) mny = vertex_c_y;
        if (vertex_b_y > mxy) mxy = vertex_b_y;
        if (vertex_c_y > mxy) mxy = vertex_c_y;
    end

    assign sx_inc   = DW'(sx_reg) + DW'(1);
    assign sy_inc   = DW'(sy_reg) + DW'(1);
    assign row_end  = (sy_inc == DW'(maxy_reg));
    assign last_hit = (sx_inc == DW'(maxx_reg)) && row_end;

    always_comb
    begin
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        active_next = active_reg;
        if (accept)
        begin
            if (is_start)
            begin
                sx_next     = mnx;
                sy_next     = mny;
                active_next = (mnx < mxx) && (mny < mxy);
            end
            else if (active_reg)
            begin
                if (last_hit)
                begin
                    sx_next     = minx_reg;
                    sy_next     = miny_reg;
                    active_next = 1'b0;
                end
                else if (row_end)
                begin
                    sx_next = sx_inc[COORD_BITS-1:0];
                    sy_next = miny_reg;
                end
                else
                begin
                    sy_next = sy_inc[COORD_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg <= sx_next;
        sy_reg <= sy_next;
        if (accept && is_start)
        begin
            ax_reg    <= vertex_a_x;
            ay_reg    <= vertex_a_y;
            dbx_reg   <= DW'(vertex_b_x) - DW'(vertex_a_x);
            dby_reg   <= DW'(vertex_b_y) - DW'(vertex_a_y);
            dcx_reg   <= DW'(vertex_c_x) - DW'(vertex_a_x);
            dcy_reg   <= DW'(vertex_c_y) - DW'(vertex_a_y);
            color_reg <= fill_color;
            minx_reg  <= mnx;
            miny_reg  <= mny;
            maxx_reg  <= mxx;
            maxy_reg  <= mxy;
        end
    end

    // scan items go to the back; starts stay here
    assign push_valid = accept && !is_start;
    assign px    = active_reg ? sx_reg : '0;
    assign py    = active_reg ? sy_reg : '0;
    assign dax   = DW'(ax_reg) - DW'(sx_reg);
    assign day   = DW'(ay_reg) - DW'(sy_reg);
    assign dbx   = dbx_reg;
    assign dby   = dby_reg;
    assign dcx   = dcx_reg;
    assign dcy   = dcy_reg;
    assign color = color_reg;
    assign act   = active_reg;
    assign last  = active_reg ? last_hit : 1'b1;

endmodule

`default_nettype wire

// ----- rtl/tbr_back.sv -----
// rasterizer back: edge products, edge sums and the coverage test
// depends on tbr_pkg
`default_nettype none

module tbr_back #(
    parameter int COORD_BITS = 13
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    output logic                               q_ready,
    input  wire logic signed [COORD_BITS-1:0]  px,
    input  wire logic signed [COORD_BITS-1:0]  py,
    input  wire logic signed [COORD_BITS:0]    dax,
    input  wire logic signed [COORD_BITS:0]    day,
    input  wire logic signed [COORD_BITS:0]    dbx,
    input  wire logic signed [COORD_BITS:0]    dby,
    input  wire logic signed [COORD_BITS:0]    dcx,
    input  wire logic signed [COORD_BITS:0]    dcy,
    input  wire logic [tbr_pkg::COLOR_BITS-1:0] color,
    input  wire logic                          act,
    input  wire logic                          last_in,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [COORD_BITS-1:0]       pixel_x,
    output logic signed [COORD_BITS-1:0]       pixel_y,
    output logic                               covered,
    output logic [tbr_pkg::COLOR_BITS-1:0]     pixel_color,
    output logic                               last
);

    import tbr_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int UW = PW + 1;
    localparam int SW = PW + 2;

    logic advance;

    logic                         s1_valid_reg;
    logic signed [PW-1:0]         p_bd_reg, p_ab_reg, p_ac_reg, p_cd_reg, p_cb_reg, p_bc_reg;
    logic signed [COORD_BITS-1:0] s1_x_reg, s1_y_reg;
    logic [COLOR_BITS-1:0]        s1_color_reg;
    logic                         s1_act_reg, s1_last_reg;

    logic                         s2_valid_reg;
    logic signed [UW-1:0]         ux_reg, uy_reg, uz_reg;
    logic signed [COORD_BITS-1:0] s2_x_reg, s2_y_reg;
    logic [COLOR_BITS-1:0]        s2_color_reg;
    logic                         s2_act_reg, s2_last_reg;

    logic                         out_valid_reg;
    logic signed [COORD_BITS-1:0] x_reg, y_reg;
    logic                         cov_reg, last_reg;
    logic [COLOR_BITS-1:0]        color_reg;

    logic signed [SW-1:0]         uv_sum;
    logic                         in_tri;

    // the whole pipe moves whenever the output register is free
    assign advance = !out_valid_reg || out_ready;
    assign q_ready = advance;

    always_comb
    begin
        uv_sum = SW'(ux_reg) + SW'(uy_reg);
        if (uz_reg > 0)
        begin
            in_tri = (ux_reg >= 0) && (uy_reg >= 0) && (uv_sum <= SW'(uz_reg));
        end
        else if (uz_reg < 0)
        begin
            in_tri = (ux_reg <= 0) && (uy_reg <= 0) && (uv_sum >= SW'(uz_reg));
        end
        else
        begin
            in_tri = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= q_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            // ux = dbx*day - dax*dby, uy = dax*dcy - dcx*day, uz = dcx*dby - dbx*dcy
            p_bd_reg     <= PW'(dbx) * PW'(day);
            p_ab_reg     <= PW'(dax) * PW'(dby);
            p_ac_reg     <= PW'(dax) * PW'(dcy);
            p_cd_reg     <= PW'(dcx) * PW'(day);
            p_cb_reg     <= PW'(dcx) * PW'(dby);
            p_bc_reg     <= PW'(dbx) * PW'(dcy);
            s1_x_reg     <= px;
            s1_y_reg     <= py;
            s1_color_reg <= color;
            s1_act_reg   <= act;
            s1_last_reg  <= last_in;

            ux_reg       <= UW'(p_bd_reg) - UW'(p_ab_reg);
            uy_reg       <= UW'(p_ac_reg) - UW'(p_cd_reg);
            uz_reg       <= UW'(p_cb_reg) - UW'(p_bc_reg);
            s2_x_reg     <= s1_x_reg;
            s2_y_reg     <= s1_y_reg;
            s2_color_reg <= s1_color_reg;
            s2_act_reg   <= s1_act_reg;
            s2_last_reg  <= s1_last_reg;

            x_reg        <= s2_x_reg;
            y_reg        <= s2_y_reg;
            cov_reg      <= s2_act_reg && in_tri;
            color_reg    <= (s2_act_reg && in_tri) ? s2_color_reg : '0;
            last_reg     <= s2_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = x_reg;
    assign pixel_y     = y_reg;
    assign covered     = cov_reg;
    assign pixel_color = color_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

// ----- tb/tb_triangle_bbox_raster.sv -----
// testbench for triangle_bbox_raster: directed table then random triangles and scans,
// each pixel checked against a typed table value or a behavioral rasterizer in this file
// depends on tbr_pkg and the triangle_bbox_raster rtl
`timescale 1ns / 100ps

module tb_triangle_bbox_raster;

    import tbr_pkg::*;

    localparam int CW        = 13;
    localparam int ITEMS     = 900;
    localparam int MAX_CYC   = 500000;
    localparam int PLAN_ROWS = 26;

    typedef struct {
        logic                  op;
        int                    ax, ay, bx, by, cx, cy;
        logic [COLOR_BITS-1:0] color;
    } stim_t;

    typedef struct packed {
        logic signed [CW-1:0]  x;
        logic signed [CW-1:0]  y;
        logic                  covered;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } pixel_t;

    typedef struct {
        stim_t  item;
        bit     typed;
        pixel_t want;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  operation;
    logic signed [CW-1:0]  vertex_a_x;
    logic signed [CW-1:0]  vertex_a_y;
    logic signed [CW-1:0]  vertex_b_x;
    logic signed [CW-1:0]  vertex_b_y;
    logic signed [CW-1:0]  vertex_c_x;
    logic signed [CW-1:0]  vertex_c_y;
    logic [COLOR_BITS-1:0] fill_color;
    logic                  out_valid;
    logic                  out_ready;
    logic signed [CW-1:0]  pixel_x;
    logic signed [CW-1:0]  pixel_y;
    logic                  covered;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last;

    // rasterizer state, mirrors the block
    longint                tri_x [3];
    longint                tri_y [3];
    longint                box_x0, box_y0, box_x1, box_y1;
    longint                cur_x, cur_y;
    longint                tri_area;
    logic [COLOR_BITS-1:0] tri_color = '0;
    bit                    scan_busy;

    pixel_t pending_pixels [$];
    int     mismatches;
    int     items_sent;
    int     cycles;
    bit     calm;
    bit     gaps_on;
    bit     hold_request;

    plan_row_t plan [PLAN_ROWS] = '{
        '{'{OP_SCAN, 4095, 4095, -4096, -4096, 4095, -1, 24'hFFFFFF}, 1, '{0, 0, 0, 0, 1}},
        '{'{OP_START, 0, 0, 0, 2, 2, 0, 24'h123456}, 0, '0},
        '{'{OP_SCAN, 0, 0, 0, 0, 0, 0, 24'h0}, 0, '0},
        '{'{OP_SCAN, 0, 0, 0, 0, 0, 0, 24'h0}, 0, '0},
        '{'{OP_SCAN, 0, 0, 0, 0, 0, 0, 24'h0}, 0, '0},
        '{'{OP_SCAN, 0, 0, 0, 0, 0, 0, 24'h0}, 0, '0},
        '{'{OP_SCAN, 0, 0, 0, 0, 0, 0, 24'h0}, 1, '{0, 0, 0, 0, 1}},
        // clockwise winding, abandoned halfway
        '{'{OP_START, 0, 0, 2, 0, 0, 2, 24'hA5A5A5}, 0, '0},
        '{'{OP_SCAN, 0, 0, 0, 0, 0, 0, 24'h0}, 0, '0},
        '{'{OP_SCAN, 0, 0, 0, 0, 0, 0, 24'h0}, 0, '0},
        // collinear vertices cover nothing
        '{'{OP_START, 0, 0, 1, 1, 2, 2, 24'hFFFFFF}, 0, '0},
        '{'{OP_SCAN, 0, 0, 0, 0, 0, 0, 24'h0}, 1, '{0, 0, 0, 0, 0}},
        '{'{OP_SCAN, 0, 0, 0, 0, 0, 0, 24'h0}, 1, '{0, 1, 0, 0, 0}},
        '{'{OP_SCAN, 0, 0, 0, 0, 0, 0, 24'h0}, 1, '{1, 0, 0, 0, 0}},
        '{'{OP_SCAN, 0, 0, 0, 0, 0, 0, 24'h0}, 1, '{1, 1, 0, 0, 1}},
        '{'{OP_SCAN, 0, 0, 0, 0, 0, 0, 24'h0}, 1, '{0, 0, 0, 0, 1}},
        '{'{OP_START, -4096, -4096, 4095, 4095, -4096, 4095, 24'hFFFFFF}, 0, '0},
        '{'{OP_SCAN, 0, 0, 0, 0, 0, 0, 24'h0}, 0, '0},
        '{'{OP_SCAN, 0, 0, 0, 0, 0, 0, 24'h0}, 0, '0},
        // zero-width box, no scan starts
        '{'{OP_START, 5, 3, 5, 7, 5, 1, 24'h00FF00}, 0, '0},
        '{'{OP_SCAN, 0, 0, 0, 0, 0, 0, 24'h0}, 1, '{0, 0, 0, 0, 1}},
        '{'{OP_START, 4095, -4096, -4096, 4095, 4095, 4095, 24'h000000}, 0, '0},
        '{'{OP_SCAN, 0, 0, 0, 0, 0, 0, 24'h0}, 0, '0},
        '{'{OP_SCAN, 0, 0, 0, 0, 0, 0, 24'h0}, 0, '0},
        '{'{OP_START, 4094, 4094, 4095, 4094, 4094, 4095, 24'hFFFFFF}, 0, '0},
        '{'{OP_SCAN, 0, 0, 0, 0, 0, 0, 24'h0}, 0, '0}
    };

    triangle_bbox_raster #(
        .COORD_BITS(CW)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .vertex_a_x  (vertex_a_x),
        .vertex_a_y  (vertex_a_y),
        .vertex_b_x  (vertex_b_x),
        .vertex_b_y  (vertex_b_y),
        .vertex_c_x  (vertex_c_x),
        .vertex_c_y  (vertex_c_y),
        .fill_color  (fill_color),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .covered     (covered),
        .pixel_color (pixel_color),
        .last        (last)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one start or scan item through the rasterizer, returns 1 when it gives a pixel
    function automatic bit raster_step(input stim_t it, output pixel_t pix);
        longint ux, uy;
        bit     cov, fin;
        pix = '0;
        if (it.op == OP_START)
        begin
            tri_x[0] = it.ax; tri_y[0] = it.ay;
            tri_x[1] = it.bx; tri_y[1] = it.by;
            tri_x[2] = it.cx; tri_y[2] = it.cy;
            tri_color = it.color;
            box_x0 = tri_x[0]; box_x1 = tri_x[0];
            box_y0 = tri_y[0]; box_y1 = tri_y[0];
            for (int i = 1; i < 3; i++)
            begin
                if (tri_x[i] < box_x0) box_x0 = tri_x[i];
                if (tri_x[i] > box_x1) box_x1 = tri_x[i];
                if (tri_y[i] < box_y0) box_y0 = tri_y[i];
                if (tri_y[i] > box_y1) box_y1 = tri_y[i];
            end
            tri_area = (tri_x[2] - tri_x[0]) * (tri_y[1] - tri_y[0])
                     - (tri_x[1] - tri_x[0]) * (tri_y[2] - tri_y[0]);
            cur_x = box_x0;
            cur_y = box_y0;
            scan_busy = (box_x0 < box_x1) && (box_y0 < box_y1);
            return 1'b0;
        end
        if (!scan_busy)
        begin
            pix.last = 1'b1;
            return 1'b1;
        end
        ux = (tri_x[1] - tri_x[0]) * (tri_y[0] - cur_y) - (tri_x[0] - cur_x) * (tri_y[1] - tri_y[0]);
        uy = (tri_x[0] - cur_x) * (tri_y[2] - tri_y[0]) - (tri_x[2] - tri_x[0]) * (tri_y[0] - cur_y);
        // sign tests stand in for the barycentric division
        if (tri_area > 0)
            cov = (ux >= 0) && (uy >= 0) && (ux + uy <= tri_area);
        else if (tri_area < 0)
            cov = (ux <= 0) && (uy <= 0) && (ux + uy >= tri_area);
        else
            cov = 1'b0;
        fin = (cur_x + 1 == box_x1) && (cur_y + 1 == box_y1);
        pix.x       = CW'(cur_x);
        pix.y       = CW'(cur_y);
        pix.covered = cov;
        pix.color   = cov ? tri_color : '0;
        pix.last    = fin;
        cur_y++;
        if (cur_y >= box_y1)
        begin
            cur_y = box_y0;
            cur_x++;
        end
        if (fin)
        begin
            scan_busy = 1'b0;
            cur_x = box_x0;
            cur_y = box_y0;
        end
        return 1'b1;
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, 8191)) - 4096;
    endfunction

    // scan item with random junk on the ignored fields
    function automatic stim_t junk_scan();
        stim_t s;
        s.op = OP_SCAN;
        s.ax = any_coord(); s.ay = any_coord();
        s.bx = any_coord(); s.by = any_coord();
        s.cx = any_coord(); s.cy = any_coord();
        s.color = $urandom();
        return s;
    endfunction

    // lower corner of a small box, sometimes pushed against the coordinate limits
    function automatic int pick_base(input int sz);
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return -4096;
        if (r == 1)
            return 4095 - sz;
        return int'($urandom_range(0, 8191 - sz)) - 4096;
    endfunction

    task automatic offer(input stim_t it, input bit typed, input pixel_t want);
        pixel_t pix;
        bit     has;
        if (!calm && gaps_on && $urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(1, 19))
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        operation  <= it.op;
        vertex_a_x <= CW'(it.ax);
        vertex_a_y <= CW'(it.ay);
        vertex_b_x <= CW'(it.bx);
        vertex_b_y <= CW'(it.by);
        vertex_c_x <= CW'(it.cx);
        vertex_c_y <= CW'(it.cy);
        fill_color <= it.color;
        do
            @(posedge clk);
        while (!in_ready);
        has = raster_step(it, pix);
        if (typed)
            pending_pixels.push_back(want);
        else if (has)
            pending_pixels.push_back(pix);
        items_sent++;
    endtask

    task automatic random_triangle();
        stim_t  st;
        int     kind, sz, x0, y0, dx, dy;
        longint n;
        kind = $urandom_range(0, 15);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 3)) offer(junk_scan(), 1'b0, '0);
            return;
        end
        st = junk_scan();
        st.op = OP_START;
        if (kind != 1)
        begin
            sz = (kind <= 3) ? 6 : $urandom_range(1, 6);
            x0 = pick_base(sz);
            y0 = pick_base(sz);
            if (kind == 2)
            begin
                // all on one column: empty box
                st.ax = x0; st.bx = x0; st.cx = x0;
                st.ay = y0 + $urandom_range(0, sz);
                st.by = y0 + $urandom_range(0, sz);
                st.cy = y0 + $urandom_range(0, sz);
            end
            else if (kind == 3)
            begin
                // collinear, zero area
                dx = $urandom_range(0, 3);
                dy = $urandom_range(0, 3);
                st.ax = x0;          st.ay = y0;
                st.bx = x0 + dx;     st.by = y0 + dy;
                st.cx = x0 + 2 * dx; st.cy = y0 + 2 * dy;
            end
            else
            begin
                st.ax = x0 + $urandom_range(0, sz); st.ay = y0 + $urandom_range(0, sz);
                st.bx = x0 + $urandom_range(0, sz); st.by = y0 + $urandom_range(0, sz);
                st.cx = x0 + $urandom_range(0, sz); st.cy = y0 + $urandom_range(0, sz);
            end
        end
        offer(st, 1'b0, '0);
        n = scan_busy ? (box_x1 - box_x0) * (box_y1 - box_y0) : 0;
        if (kind == 1)
            n = $urandom_range(1, 5);
        else if ($urandom_range(0, 7) == 0)
            n = $urandom_range(0, int'(n));
        else if ($urandom_range(0, 5) == 0)
            n = n + 1;
        repeat (n) offer(junk_scan(), 1'b0, '0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, $signed(want), $signed(got));
            mismatches++;
        end
    endtask

    initial
    begin
        int seq;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = OP_SCAN;
        vertex_a_x   = '0;
        vertex_a_y   = '0;
        vertex_b_x   = '0;
        vertex_b_y   = '0;
        vertex_c_x   = '0;
        vertex_c_y   = '0;
        fill_color   = '0;
        calm         = 1'b0;
        gaps_on      = 1'b1;
        hold_request = 1'b0;
        mismatches   = 0;
        items_sent   = 0;
        seq          = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++)
            offer(plan[i].item, plan[i].typed, plan[i].want);

        while (items_sent < ITEMS)
        begin
            seq++;
            if (seq == 20)
            begin
                // output held off while items keep coming, input must back up
                gaps_on = 1'b0;
                hold_request = 1'b1;
                repeat (30) offer(junk_scan(), 1'b0, '0);
                gaps_on = 1'b1;
            end
            if (items_sent > ITEMS - 120)
                calm = 1'b1;
            if (!calm && seq % 37 == 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                while (pending_pixels.size() != 0)
                    @(posedge clk);
            end
            random_triangle();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("** triangle_bbox_raster: PASSED **");
        else
            $display("** triangle_bbox_raster: FAILED **");
        $finish;
    end

    // output side: random ready bursts, one long hold on request
    initial
    begin
        int   run_left;
        logic level;
        run_left  = 0;
        level     = 1'b1;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                level = 1'b0;
                run_left = 80;
            end
            else if (calm)
            begin
                level = 1'b1;
                run_left = 1;
            end
            else if (run_left == 0)
            begin
                int r;
                r = $urandom_range(0, 9);
                if (r < 3)
                begin
                    level = 1'b0;
                    run_left = $urandom_range(1, 19);
                end
                else if (r == 9)
                begin
                    level = 1'b1;
                    run_left = $urandom_range(100, 200);
                end
                else
                begin
                    level = 1'b1;
                    run_left = $urandom_range(1, 30);
                end
            end
            out_ready <= level;
            run_left--;
        end
    end

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel x %0d y %0d", $time, pixel_x, pixel_y);
                mismatches++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("pixel_x", 32'($signed(want.x)), 32'($signed(pixel_x)));
                check_field("pixel_y", 32'($signed(want.y)), 32'($signed(pixel_y)));
                check_field("covered", 32'(want.covered), 32'(covered));
                check_field("pixel_color", 32'(want.color), 32'(pixel_color));
                check_field("last", 32'(want.last), 32'(last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYC)
        begin
            $display("** triangle_bbox_raster: FAILED **");
            $finish;
        end
    end

endmodule
